// ===== hw/rtl/pklw_pkg.sv =====
// Package for the per-key latency watchdog table: sizes, operation and
// event codes, and the request and response payload structs. No dependencies.
`default_nettype none
package pklw_pkg;
   localparam int TABLE_ENTRIES = 16;
   localparam int TIME_BITS     = 48;
   localparam int LIMIT_BITS    = 32;
   localparam int KEY_BITS      = 16;
   localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);

   localparam logic [2:0] OP_FLUSH  = 3'd0;
   localparam logic [2:0] OP_SERVED = 3'd1;
   localparam logic [2:0] OP_CHECK  = 3'd2;
   localparam logic [2:0] OP_REMOVE = 3'd3;
   localparam logic [2:0] OP_QUERY  = 3'd4;

   localparam logic [1:0] EV_EXCEEDED = 2'd0;
   localparam logic [1:0] EV_BELOW    = 2'd1;
   localparam logic [1:0] EV_QUERY    = 2'd2;
   localparam logic [1:0] EV_FULL     = 2'd3;

   typedef struct packed {
      logic [2:0]            operation;
      logic [KEY_BITS-1:0]   scene_key;
      logic [47:0]           time_value;
      logic [31:0]           latency_limit;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]          event_kind;
      logic [KEY_BITS-1:0] event_key;
      logic                is_monitored;
      logic                last_of_run;
   } rsp_payload_type;

   // Token passed along the chain of cells, one cell per cycle.
   typedef struct packed {
      logic                  active;
      logic                  commit;   // insert pass of a flush
      logic [2:0]            operation;
      logic [KEY_BITS-1:0]   key;
      logic [TIME_BITS-1:0]  time_value;
      logic [LIMIT_BITS-1:0] limit;
      logic                  found;    // key already matched an earlier cell
      logic                  free_seen; // an earlier free cell was seen
   } token_type;

   // Event produced by one cell during a check.
   typedef struct packed {
      logic                valid;
      logic [1:0]          kind;
      logic [KEY_BITS-1:0] key;
   } cell_event_type;
endpackage
`default_nettype wire

// ===== hw/rtl/pklw_cell.sv =====
// One table entry of the watchdog chain: holds key, stamps, limit and flags,
// and acts on the token passing through it. Depends on pklw_pkg.
`default_nettype none
module pklw_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pklw_pkg::token_type     tok_in,
   output pklw_pkg::token_type          tok_out,
   output pklw_pkg::cell_event_type     evt
);
   import pklw_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  flag_ff, flag_in;
   logic [KEY_BITS-1:0]   key_ff;
   logic [TIME_BITS-1:0]  applied_ff, served_ff;
   logic [LIMIT_BITS-1:0] limit_ff;
   token_type             tok_ff, tok_next;
   logic                  hit, free_here, do_insert, do_update, do_served, over;
   logic [TIME_BITS-1:0]  elapsed;

   assign hit       = tok_in.active && valid_ff && (key_ff == tok_in.key) && !tok_in.found;
   assign free_here = tok_in.active && !valid_ff && !tok_in.free_seen;
   // The insert pass fills the first free cell it meets.
   assign do_insert = free_here && tok_in.commit;
   assign do_update = hit && !tok_in.commit && (tok_in.operation == OP_FLUSH);
   assign do_served = hit && !tok_in.commit && (tok_in.operation == OP_SERVED);
   assign elapsed   = (tok_in.time_value > served_ff) ? tok_in.time_value - served_ff
                                                      : '0;
   assign over      = ({{(64-TIME_BITS){1'b0}}, elapsed} >
                       {{(64-LIMIT_BITS){1'b0}}, limit_ff});

   always_comb begin
      valid_in = valid_ff;
      flag_in  = flag_ff;
      evt      = '0;
      tok_next = tok_in;
      if (hit) tok_next.found = 1'b1;
      if (free_here) tok_next.free_seen = 1'b1;
      if (do_insert) begin
         valid_in = 1'b1;
         flag_in  = 1'b0;
      end else if (tok_in.active && !tok_in.commit) begin
         unique case (tok_in.operation)
            OP_CHECK: begin
               if (valid_ff && limit_ff != '0) begin
                  flag_in = over;
                  if (over != flag_ff) begin
                     evt.valid = 1'b1;
                     evt.kind  = over ? EV_EXCEEDED : EV_BELOW;
                     evt.key   = key_ff;
                  end
               end
            end
            OP_REMOVE: begin
               if (hit) begin
                  valid_in = 1'b0;
                  flag_in  = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         flag_ff  <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         flag_ff  <= flag_in;
         tok_ff   <= tok_next;
         if (do_insert) begin
            key_ff     <= tok_in.key;
            applied_ff <= tok_in.time_value;
            served_ff  <= tok_in.time_value;
            limit_ff   <= tok_in.limit;
         end else if (do_update) begin
            applied_ff <= tok_in.time_value;
            limit_ff   <= tok_in.limit;
         end else if (do_served) begin
            served_ff  <= applied_ff;
         end
      end
   end

   assign tok_out = tok_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/per_key_latency_watchdog_table.sv =====
// Top level of the per-key latency watchdog table: sequencer, chain of
// cells and response queue. Depends on pklw_pkg and pklw_cell.
//
// The table is a chain of TABLE_ENTRIES cells. An accepted request is held in
// a register and enters the chain as a token in the next cycle; the token
// moves one cell per cycle, and the search result is read at the end of the
// chain once the token has left the last cell. Results are then handed out
// one per cycle while rsp_ready is high, and the block returns to idle once
// the result queue is empty. A flush of an unknown key with a nonzero limit
// and a free entry makes a second pass that inserts into the lowest free
// entry. Checks record their events in entry order as the token passes
// each cell; a new request is held off until all results have been taken.
`default_nettype none
module per_key_latency_watchdog_table (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire pklw_pkg::req_payload_type  req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output pklw_pkg::rsp_payload_type       rsp_payload
);
   import pklw_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_INSERT = 4'b0100,
      ST_DRAIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   token_type chain [TABLE_ENTRIES+1];
   token_type inject;
   cell_event_type evts [TABLE_ENTRIES];
   cell_event_type walk_evt;
   logic [CNT_BITS-1:0]  step_ff, step_in;
   req_payload_type      req_ff;
   logic                 walk_done, want_insert;

   // Result queue: a check yields at most one result per entry.
   logic [1:0]          q_kind [TABLE_ENTRIES+1];
   logic [KEY_BITS-1:0] q_key  [TABLE_ENTRIES+1];
   logic                q_mon  [TABLE_ENTRIES+1];
   logic [CNT_BITS-1:0] q_wr_ff, q_rd_ff;
   logic                push;
   logic [1:0]          push_kind;
   logic [KEY_BITS-1:0] push_key;
   logic                push_mon;

   assign chain[0] = inject;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      pklw_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain[g]),
         .tok_out (chain[g+1]),
         .evt     (evts[g])
      );
   end

   // The token enters the first cell in the first cycle of each pass.
   always_comb begin
      inject            = '0;
      inject.active     = ((state_ff == ST_WALK) || (state_ff == ST_INSERT))
                          && (step_ff == '0);
      inject.commit     = (state_ff == ST_INSERT);
      inject.operation  = req_ff.operation;
      inject.key        = req_ff.scene_key;
      inject.time_value = req_ff.time_value[TIME_BITS-1:0];
      inject.limit      = req_ff.latency_limit[LIMIT_BITS-1:0];
   end

   assign req_ready = (state_ff == ST_IDLE);
   // At step s the token sits at cell s; at the last step it has left the chain.
   assign walk_done = (step_ff == CNT_BITS'(TABLE_ENTRIES));
   assign walk_evt  = evts[step_ff[IDX_BITS-1:0]];
   assign want_insert = (req_ff.operation == OP_FLUSH) && !chain[TABLE_ENTRIES].found
                        && (req_ff.latency_limit[LIMIT_BITS-1:0] != '0);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_WALK;
               step_in  = '0;
            end
         end
         ST_WALK: begin
            step_in = step_ff + CNT_BITS'(1);
            if (walk_done) begin
               step_in = '0;
               if (want_insert && chain[TABLE_ENTRIES].free_seen) state_in = ST_INSERT;
               else state_in = ST_DRAIN;
            end
         end
         ST_INSERT: begin
            step_in = step_ff + CNT_BITS'(1);
            if (walk_done) begin
               step_in  = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: if (q_rd_ff == q_wr_ff) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Results found during the walk: check events cell by cell, then the query
   // answer or the table-full result once the whole chain was searched.
   always_comb begin
      push      = 1'b0;
      push_kind = walk_evt.kind;
      push_key  = walk_evt.key;
      push_mon  = 1'b0;
      if (state_ff == ST_WALK) begin
         if (!walk_done) begin
            push = walk_evt.valid;
         end else if (req_ff.operation == OP_QUERY) begin
            push      = 1'b1;
            push_kind = EV_QUERY;
            push_key  = req_ff.scene_key;
            push_mon  = chain[TABLE_ENTRIES].found;
         end else if (want_insert && !chain[TABLE_ENTRIES].free_seen) begin
            push      = 1'b1;
            push_kind = EV_FULL;
            push_key  = req_ff.scene_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (req_valid && req_ready) begin
            req_ff  <= req_payload;
            q_wr_ff <= '0;
            q_rd_ff <= '0;
         end else begin
            if (push) q_wr_ff <= q_wr_ff + CNT_BITS'(1);
            if (rsp_valid && rsp_ready) q_rd_ff <= q_rd_ff + CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_kind[q_wr_ff] <= push_kind;
         q_key[q_wr_ff]  <= push_key;
         q_mon[q_wr_ff]  <= push_mon;
      end
   end

   assign rsp_valid = (state_ff == ST_DRAIN) && (q_rd_ff != q_wr_ff);
   always_comb begin
      rsp_payload              = '0;
      rsp_payload.event_kind   = q_kind[q_rd_ff];
      rsp_payload.event_key    = q_key[q_rd_ff];
      rsp_payload.is_monitored = q_mon[q_rd_ff];
      rsp_payload.last_of_run  = ((q_rd_ff + CNT_BITS'(1)) == q_wr_ff);
   end
endmodule
`default_nettype wire

// ===== hw/rtl/pklw_checker.sv =====
// Port-level checker for the watchdog table and its bind statement.
// Depends on pklw_pkg and per_key_latency_watchdog_table.
`default_nettype none
module pklw_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire pklw_pkg::rsp_payload_type rsp_payload
);
   import pklw_pkg::*;

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while results pending");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");
   a_query_mon: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_kind != EV_QUERY |-> !rsp_payload.is_monitored)
      else $error("membership bit outside query answer");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after accept");
endmodule

bind per_key_latency_watchdog_table pklw_checker u_pklw_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload));
`default_nettype wire

// ===== tb/per_key_latency_watchdog_table_tb.sv =====
// Testbench for the per-key latency watchdog table: random and directed requests
// checked against a behavioral table model. Depends on pklw_pkg and the RTL top.
`default_nettype none
module per_key_latency_watchdog_table_tb;
   import pklw_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   rsp_payload_type rsp_payload;

   per_key_latency_watchdog_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   // Behavioral copy of the table, updated when each request is accepted.
   logic                  tbl_valid   [TABLE_ENTRIES];
   logic [KEY_BITS-1:0]   tbl_key     [TABLE_ENTRIES];
   logic [TIME_BITS-1:0]  tbl_applied [TABLE_ENTRIES];
   logic [TIME_BITS-1:0]  tbl_served  [TABLE_ENTRIES];
   logic [LIMIT_BITS-1:0] tbl_limit   [TABLE_ENTRIES];
   logic                  tbl_over    [TABLE_ENTRIES];

   req_payload_type pending_requests[$];
   rsp_payload_type expected_events[$];
   int  mismatches;
   bit  hold_sender;   // set by the stimulus to pause until the table drains
   int  calm_start;    // first cycle of the window in which neither side idles
   int  cycle;

   // Predicts the events caused by one request and advances the table copy.
   function automatic void predict_events(req_payload_type r);
      rsp_payload_type ev[$];
      rsp_payload_type e;
      int idx;
      int slot;
      logic [TIME_BITS-1:0] elapsed;
      logic now_over;
      idx = -1;
      slot = -1;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (tbl_valid[i] && tbl_key[i] == r.scene_key) idx = i;
         if (!tbl_valid[i]) slot = i;
      end
      e = '0;
      case (r.operation)
         OP_FLUSH: begin
            if (idx >= 0) begin
               tbl_applied[idx] = r.time_value;
               tbl_limit[idx] = r.latency_limit;
            end else if (r.latency_limit != 0) begin
               if (slot >= 0) begin
                  tbl_valid[slot] = 1'b1;
                  tbl_key[slot] = r.scene_key;
                  tbl_applied[slot] = r.time_value;
                  tbl_served[slot] = r.time_value;
                  tbl_limit[slot] = r.latency_limit;
                  tbl_over[slot] = 1'b0;
               end else begin
                  e.event_kind = EV_FULL;
                  e.event_key = r.scene_key;
                  ev.push_back(e);
               end
            end
         end
         OP_SERVED: if (idx >= 0) tbl_served[idx] = tbl_applied[idx];
         OP_CHECK: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (tbl_valid[i] && tbl_limit[i] != 0) begin
                  elapsed = (r.time_value > tbl_served[i]) ?
                            r.time_value - tbl_served[i] : '0;
                  now_over = elapsed > TIME_BITS'(tbl_limit[i]);
                  if (now_over != tbl_over[i]) begin
                     e.event_kind = now_over ? EV_EXCEEDED : EV_BELOW;
                     e.event_key = tbl_key[i];
                     ev.push_back(e);
                  end
                  tbl_over[i] = now_over;
               end
            end
         end
         OP_REMOVE: if (idx >= 0) begin
            tbl_valid[idx] = 1'b0;
            tbl_over[idx] = 1'b0;
         end
         OP_QUERY: begin
            e.event_kind = EV_QUERY;
            e.event_key = r.scene_key;
            e.is_monitored = (idx >= 0);
            ev.push_back(e);
         end
         default: ;
      endcase
      if (ev.size() > 0) ev[ev.size()-1].last_of_run = 1'b1;
      foreach (ev[i]) expected_events.push_back(ev[i]);
   endfunction

   function automatic req_payload_type make_request(logic [2:0] op, logic [15:0] key,
                                                    logic [47:0] t, logic [31:0] lim);
      req_payload_type r;
      r.operation = op;
      r.scene_key = key;
      r.time_value = t;
      r.latency_limit = lim;
      return r;
   endfunction

   function automatic bit take_a_break();
      if (cycle >= calm_start && cycle < calm_start + 3000) return 1'b0;
      return $urandom_range(99) < 30;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle <= reset ? 0 : cycle + 1;

   // Driver: presents the oldest pending request and keeps it steady until
   // accepted. A new request is loaded only when the slot is free or the
   // current one is taken on this very edge, so valid is never dropped and
   // raised within one step.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_over[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_applied[i] = '0;
            tbl_served[i] = '0;
            tbl_limit[i] = '0;
         end
      end else begin
         if (!req_valid || req_ready) begin
            if (req_valid) predict_events(req_payload);
            if (pending_requests.size() > 0 && !take_a_break() &&
                !(hold_sender && expected_events.size() > 0)) begin
               req_payload <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted event with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected event kind=%0d key=%h mon=%b last=%b",
                           rsp_payload.event_kind, rsp_payload.event_key,
                           rsp_payload.is_monitored, rsp_payload.last_of_run);
            end else begin
               rsp_payload_type want;
               want = expected_events.pop_front();
               if (rsp_payload !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"event mismatch: expected kind=%0d key=%h mon=%b last=%b,",
                               " got kind=%0d key=%h mon=%b last=%b"},
                              want.event_kind, want.event_key, want.is_monitored,
                              want.last_of_run, rsp_payload.event_kind,
                              rsp_payload.event_key, rsp_payload.is_monitored,
                              rsp_payload.last_of_run);
               end
            end
         end
         rsp_ready <= !take_a_break();
      end
   end

   // Stimulus. Keys come from a small pool so that flushes, served marks,
   // removes and queries hit the same entries, and the table really fills.
   initial begin
      logic [47:0] now;
      logic [15:0] key_pool[20];
      int pick;
      hold_sender = 1'b0;
      calm_start = $urandom_range(500, 2500);
      reset = 1'b1;
      for (int i = 0; i < 20; i++) key_pool[i] = 16'($urandom);
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;

      // Directed part: query of an absent key, zero-limit flush of an unknown
      // key, an insert, limits at both ends, crossing and coming back
      // under a limit, a check earlier than the served stamp, refresh to a zero
      // limit, served and remove of unknown keys, unused codes, maximum time.
      pending_requests.push_back(make_request(OP_QUERY, 16'h0000, '0, '0));
      pending_requests.push_back(make_request(OP_FLUSH, 16'h0000, '0, '0));
      pending_requests.push_back(make_request(OP_QUERY, 16'h0000, '0, '0));
      pending_requests.push_back(make_request(OP_FLUSH, 16'h0000, 48'd100, 32'd10));
      pending_requests.push_back(make_request(OP_FLUSH, 16'hFFFF, 48'd100,
                                              32'hFFFF_FFFF));
      pending_requests.push_back(make_request(OP_CHECK, 16'h1234, 48'd50, '0));
      pending_requests.push_back(make_request(OP_CHECK, 16'h1234, 48'd110, '0));
      pending_requests.push_back(make_request(OP_CHECK, 16'h1234, 48'd111, '0));
      pending_requests.push_back(make_request(OP_FLUSH, 16'h0000, 48'd200, 32'd10));
      pending_requests.push_back(make_request(OP_SERVED, 16'h0000, '0, '0));
      pending_requests.push_back(make_request(OP_CHECK, 16'h0000, 48'd205, '0));
      pending_requests.push_back(make_request(OP_CHECK, 16'h0000, 48'hFFFF_FFFF_FFFF, '0));
      pending_requests.push_back(make_request(OP_FLUSH, 16'hFFFF, 48'd5, '0));
      pending_requests.push_back(make_request(OP_CHECK, 16'h0000, '0, '0));
      pending_requests.push_back(make_request(OP_SERVED, 16'hABCD, '0, '0));
      pending_requests.push_back(make_request(OP_REMOVE, 16'hABCD, '0, '0));
      pending_requests.push_back(make_request(3'd5, 16'h0000, '1, '1));
      pending_requests.push_back(make_request(3'd6, 16'hFFFF, '1, '1));
      pending_requests.push_back(make_request(3'd7, 16'h5555, '0, '0));
      pending_requests.push_back(make_request(OP_QUERY, 16'hFFFF, '1, '1));
      pending_requests.push_back(make_request(OP_REMOVE, 16'hFFFF, '0, '0));
      pending_requests.push_back(make_request(OP_QUERY, 16'hFFFF, '0, '0));
      // Fill past capacity so a table-full event appears.
      for (int i = 0; i < TABLE_ENTRIES + 2; i++)
         pending_requests.push_back(make_request(OP_FLUSH, 16'(16'h8000 + i),
                                                 48'd300, 32'd1));
      pending_requests.push_back(make_request(OP_CHECK, 16'h0, 48'd400, '0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Let the directed part drain, then empty the table so the random part
      // starts from a known population; the pause also exercises a sender hold.
      hold_sender = 1'b1;
      wait (pending_requests.size() == 0 && expected_events.size() == 0);
      for (int i = 0; i < TABLE_ENTRIES + 2; i++)
         pending_requests.push_back(make_request(OP_REMOVE, 16'(16'h8000 + i), '0, '0));
      pending_requests.push_back(make_request(OP_REMOVE, 16'h0000, '0, '0));
      @(posedge clock);
      hold_sender = 1'b0;

      // Random part: time moves forward with a few wild values, checks land on
      // both sides of the limits, and noise covers every field bit.
      now = 48'd1000;
      for (int n = 0; n < 110; n++) begin
         pick = $urandom_range(99);
         now = now + 48'($urandom_range(0, 40));
         if (pick < 30)
            pending_requests.push_back(make_request(OP_FLUSH, key_pool[$urandom_range(19)],
                                                    now, $urandom_range(0, 60)));
         else if (pick < 45)
            pending_requests.push_back(make_request(OP_SERVED,
                                                    key_pool[$urandom_range(19)], '0, '0));
         else if (pick < 70)
            pending_requests.push_back(make_request(OP_CHECK, 16'($urandom),
                                                    now + 48'($urandom_range(0, 80)), '0));
         else if (pick < 78)
            pending_requests.push_back(make_request(OP_REMOVE,
                                                    key_pool[$urandom_range(19)], '0, '0));
         else if (pick < 90)
            pending_requests.push_back(make_request(OP_QUERY,
                                                    key_pool[$urandom_range(19)], '0, '0));
         else
            pending_requests.push_back(make_request(3'($urandom_range(0, 7)),
                                                    16'($urandom),
                                                    48'({$urandom, $urandom}),
                                                    $urandom));
         if (n == 60) begin
            wait (pending_requests.size() == 0);
            hold_sender = 1'b1;
            wait (expected_events.size() == 0);
            @(posedge clock);
            hold_sender = 1'b0;
         end
      end

      wait (pending_requests.size() == 0 && !req_valid);
      wait (expected_events.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_events.size() == 0)
         $display("PASS per_key_latency_watchdog_table");
      else
         $display("FAIL per_key_latency_watchdog_table");
      $finish;
   end

   initial begin
      #5000000;
      $display("FAIL per_key_latency_watchdog_table");
      $finish;
   end
endmodule
`default_nettype wire
